// ----- hw/rtl/ptcr_pkg.sv -----
package ptcr_pkg;

  // Configured tree depth and the usable depth given a 32-bit path register
  localparam int MAX_DEPTH  = 32;
  localparam int PathWidth  = 32;
  localparam int DepthLimit = (MAX_DEPTH < PathWidth) ? MAX_DEPTH : PathWidth;

  // Walk operation codes
  localparam logic [1:0] OP_DESCEND = 2'd0;
  localparam logic [1:0] OP_LEAF    = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_ROOT_OR_DONE = 2'd1;
  localparam logic [1:0] ERR_DEPTH        = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  leaf_symbol;
    logic [8:0]  leaf_index;
    logic        tree_done;
    logic [1:0]  error_code;
  } out_word_t;

  // Walk state: root-to-node path and leaf count
  typedef struct packed {
    logic [31:0] path_bits;
    logic [5:0]  path_depth;
    logic [8:0]  leaf_counter;
  } ptcr_state_t;

endpackage

// ----- hw/rtl/preorder_tree_code_rebuilder_top.sv -----
// Preorder tree code rebuilder.
// Takes the preorder walk of a prefix code tree, one word per cycle while
// in_ready_o is high, on the in channel (valid/ready): descend, leaf with
// its symbol, or finish with the final leaf. Each leaf word, each finish
// word and each error case puts one result word on the out channel
// (valid/ready) with the leaf code, its length, symbol, preorder index,
// done flag and error code. A plain descend gives no result.
// A word accepted on the in channel lands in the input register; its
// result is registered in the output register, which drives out_valid_o.
// Throughput is one word per cycle while the receiver keeps up, set by
// the combinational path update (trailing-ones count and shift) between
// the input and result registers.
// When the receiver stalls, the result waits in the output register and the
// input register still takes one more word; further words are held off by
// in_ready_o until the result is taken. Descend words keep flowing while
// they produce nothing.
// Reset clears both registers' valid flags and the path, depth and leaf
// count, so the next word starts a new tree at the root.
module preorder_tree_code_rebuilder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptcr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptcr_pkg::out_word_t out_data_o
);
  import ptcr_pkg::*;

  logic        in_valid_q, in_valid_d;
  in_word_t    in_word_q;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q;
  ptcr_state_t state_q, state_d;
  ptcr_state_t step_state;
  logic        step_has_result;
  out_word_t   step_result;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  ptcr_step u_step (
    .state_i      (state_q),
    .word_i       (in_word_q),
    .state_o      (step_state),
    .has_result_o (step_has_result),
    .result_o     (step_result)
  );

  // Flow control
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!step_has_result || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && step_has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign state_d = advance ? step_state : state_q;

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_data_i;
    end
    if (advance && step_has_result) begin
      out_word_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// ----- hw/rtl/ptcr_step.sv -----
module ptcr_step (
  input  ptcr_pkg::ptcr_state_t state_i,
  input  ptcr_pkg::in_word_t    word_i,
  output ptcr_pkg::ptcr_state_t state_o,
  output logic                  has_result_o,
  output ptcr_pkg::out_word_t   result_o
);
  import ptcr_pkg::*;

  logic [32:0] ext_bits;
  logic [32:0] flip_mask;
  logic [5:0]  flip_count;
  logic [5:0]  trail_ones;
  logic [31:0] climbed_bits;

  // Trailing ones: x ^ (x + 1) marks them plus the first zero above
  assign ext_bits  = {1'b0, state_i.path_bits};
  assign flip_mask = ext_bits ^ (ext_bits + 33'd1);

  // Mask is contiguous from bit 0, so its highest set bit gives the run length
  always_comb begin
    flip_count = '0;
    for (int i = 0; i < 33; i++) begin
      if (flip_mask[i]) begin
        flip_count = 6'(i + 1);
      end
    end
  end

  assign trail_ones   = flip_count - 6'd1;
  assign climbed_bits = (state_i.path_bits >> trail_ones) | 32'd1;

  // One walk step
  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    result_o     = '0;
    unique case (word_i.operation)
      OP_DESCEND: begin
        if (state_i.path_depth >= 6'(DepthLimit)) begin
          has_result_o         = 1'b1;
          result_o.code_bits   = state_i.path_bits;
          result_o.code_length = state_i.path_depth;
          result_o.leaf_index  = state_i.leaf_counter;
          result_o.error_code  = ERR_DEPTH;
        end else begin
          state_o.path_bits  = {state_i.path_bits[30:0], 1'b0};
          state_o.path_depth = state_i.path_depth + 6'd1;
        end
      end
      OP_LEAF: begin
        has_result_o         = 1'b1;
        result_o.leaf_symbol = word_i.symbol;
        result_o.leaf_index  = state_i.leaf_counter;
        if (state_i.path_depth == 6'd0) begin
          result_o.error_code = ERR_ROOT_OR_DONE;
        end else begin
          result_o.code_bits    = state_i.path_bits;
          result_o.code_length  = state_i.path_depth;
          state_o.leaf_counter  = state_i.leaf_counter + 9'd1;
          // All ones on the path: tree complete, back to the root
          if (trail_ones == state_i.path_depth) begin
            result_o.error_code = ERR_ROOT_OR_DONE;
            state_o.path_bits   = '0;
            state_o.path_depth  = '0;
          end else begin
            result_o.error_code = ERR_OK;
            state_o.path_bits   = climbed_bits;
            state_o.path_depth  = state_i.path_depth - trail_ones;
          end
        end
      end
      OP_FINISH: begin
        has_result_o         = 1'b1;
        result_o.code_bits   = state_i.path_bits;
        result_o.code_length = state_i.path_depth;
        result_o.leaf_symbol = word_i.symbol;
        result_o.leaf_index  = state_i.leaf_counter;
        result_o.tree_done   = 1'b1;
        result_o.error_code  = ERR_OK;
        state_o              = '0;
      end
      default: begin
        // unused operation: no result, state kept
      end
    endcase
  end

endmodule

// ----- hw/rtl/ptcr_checker.sv -----
module ptcr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ptcr_pkg::out_word_t out_data_o
);
  import ptcr_pkg::*;

  // Stalled result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result holds its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  // Code length never exceeds the path register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.code_length <= 6'(DepthLimit))
    else $error("code length beyond depth limit");

  // A clean non-final leaf always has a nonempty code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tree_done && out_data_o.error_code == ERR_OK
      |-> out_data_o.code_length != 6'd0)
    else $error("clean leaf with empty code");

  // Finish results never carry an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tree_done |-> out_data_o.error_code == ERR_OK)
    else $error("finish result flagged");

endmodule

bind preorder_tree_code_rebuilder_top ptcr_checker u_ptcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sv/preorder_tree_code_rebuilder_top_test.sv -----
`timescale 1ns / 1ps

module preorder_tree_code_rebuilder_top_test;
  import ptcr_pkg::*;

  // Operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles with no handshake on either side before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // Idle percentage per side, and the window of cycles with no idling
  localparam int IDLE_PCT = 29;
  localparam int CALM_FROM = 600;
  localparam int CALM_TO = 1500;

  // Walk word waiting to be sent; hold makes the sender drain results first
  typedef struct packed {
    logic     hold;
    in_word_t word;
  } walk_item_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  walk_item_t walk_q[$];
  out_word_t  leaf_codes_q[$];
  in_word_t   tree_q[$];

  // Shadow of the walk state
  logic [31:0] path_bits;
  logic [5:0]  path_depth;
  logic [8:0]  leaf_count;

  int mismatches = 0;
  int results_seen = 0;
  int cycle_cnt = 0;
  int stuck = 0;
  logic calm;

  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  preorder_tree_code_rebuilder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic log_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d %s: got %h, want %h", results_seen, name, got,
                             want));
    end
  endtask

  // Advance the shadow walk by one accepted word and queue its leaf code, if any
  task automatic rebuild_step(input in_word_t w);
    logic [31:0] nxt_bits;
    logic [5:0]  nxt_depth;
    logic [1:0]  err;
    case (w.operation)
      OP_DESCEND: begin
        if (path_depth >= DepthLimit) begin
          leaf_codes_q.push_back('{path_bits, path_depth, 8'd0, leaf_count, 1'b0, ERR_DEPTH});
        end else begin
          path_bits = path_bits << 1;
          path_depth = path_depth + 6'd1;
        end
      end
      OP_LEAF: begin
        if (path_depth == 6'd0) begin
          leaf_codes_q.push_back('{32'd0, 6'd0, w.symbol, leaf_count, 1'b0,
                                   ERR_ROOT_OR_DONE});
        end else begin
          // strip trailing ones, then step to the right sibling
          nxt_bits = path_bits;
          nxt_depth = path_depth;
          while (nxt_depth != 6'd0 && nxt_bits[0]) begin
            nxt_bits = nxt_bits >> 1;
            nxt_depth = nxt_depth - 6'd1;
          end
          err = ERR_OK;
          if (nxt_depth == 6'd0) begin
            err = ERR_ROOT_OR_DONE;
            nxt_bits = '0;
          end else begin
            nxt_bits[0] = 1'b1;
          end
          leaf_codes_q.push_back('{path_bits, path_depth, w.symbol, leaf_count, 1'b0, err});
          leaf_count = leaf_count + 9'd1;
          path_bits = nxt_bits;
          path_depth = nxt_depth;
        end
      end
      OP_FINISH: begin
        leaf_codes_q.push_back('{path_bits, path_depth, w.symbol, leaf_count, 1'b1, ERR_OK});
        path_bits = '0;
        path_depth = '0;
        leaf_count = '0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [1:0] op, input logic [7:0] sym, input logic hold);
    walk_item_t it;
    it.hold = hold;
    it.word.operation = op;
    it.word.symbol = sym;
    walk_q.push_back(it);
  endtask

  // Preorder walk of a random tree into tree_q; shape biases which children branch
  task automatic grow_tree(input int cap, input int shape, input int budget);
    int       depth_stk[$];
    bit       left_stk[$];
    int       d;
    bit       lft;
    int       pct;
    in_word_t w;
    tree_q.delete();
    depth_stk.push_back(0);
    left_stk.push_back(1'b0);
    while (depth_stk.size() != 0) begin
      d = depth_stk.pop_back();
      lft = left_stk.pop_back();
      case (shape)
        0: pct = 45;
        1: pct = lft ? 10 : 85;
        2: pct = lft ? 85 : 10;
        default: pct = lft ? 100 : 0;
      endcase
      if (d == 0) pct = (shape == 3) ? 0 : 5;
      w.symbol = 8'($urandom_range(0, 255));
      if (d >= cap || budget <= 0 || $urandom_range(0, 99) < pct) begin
        w.operation = OP_LEAF;
      end else begin
        w.operation = OP_DESCEND;
        depth_stk.push_back(d + 1);
        left_stk.push_back(1'b0);
        depth_stk.push_back(d + 1);
        left_stk.push_back(1'b1);
      end
      tree_q.push_back(w);
      budget--;
    end
  endtask

  // Sender: presents queued walk words, holds valid until taken
  always @(posedge clk_i) begin : drive_words
    logic       take;
    walk_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) rebuild_step(in_word);
      if (in_valid && !take) begin
        // word still pending, keep it stable
      end else if (walk_q.size() != 0 && !(walk_q[0].hold && leaf_codes_q.size() != 0) &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = walk_q.pop_front();
        in_valid <= 1'b1;
        in_word <= nxt.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, field-by-field compare, hang watchdog
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid && out_ready) begin
        if (leaf_codes_q.size() == 0) begin
          log_mismatch($sformatf("result %0d with nothing expected: %h", results_seen,
                                 out_word));
        end else begin
          want = leaf_codes_q.pop_front();
          check_field("code_bits", out_word.code_bits, want.code_bits);
          check_field("code_length", 32'(out_word.code_length), 32'(want.code_length));
          check_field("leaf_symbol", 32'(out_word.leaf_symbol), 32'(want.leaf_symbol));
          check_field("leaf_index", 32'(out_word.leaf_index), 32'(want.leaf_index));
          check_field("tree_done", 32'(out_word.tree_done), 32'(want.tree_done));
          check_field("error_code", 32'(out_word.error_code), 32'(want.error_code));
        end
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (stuck >= STALL_LIMIT) begin
        $display("preorder_tree_code_rebuilder_top verification failed");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_walks
    int       rand_words;
    int       leaf_run;
    bit       wrapped;
    bit       hold_first;
    int       shape;
    int       cap;
    int       pick;
    int       k;
    in_word_t w;

    path_bits = '0;
    path_depth = '0;
    leaf_count = '0;

    // leaf at root, one-leaf tree, ignored operation
    queue_word(OP_LEAF, 8'hFF, 1'b0);
    queue_word(OP_FINISH, 8'h00, 1'b0);
    queue_word(OP_UNUSED, 8'hA5, 1'b0);
    // two-leaf tree closed by a leaf: climbs past the complete tree
    queue_word(OP_DESCEND, 8'h00, 1'b0);
    queue_word(OP_LEAF, 8'h01, 1'b0);
    queue_word(OP_LEAF, 8'h80, 1'b0);
    // ordinary tree: codes 0, 10, 11
    queue_word(OP_DESCEND, 8'h00, 1'b0);
    queue_word(OP_LEAF, 8'h12, 1'b0);
    queue_word(OP_DESCEND, 8'h00, 1'b0);
    queue_word(OP_LEAF, 8'h34, 1'b0);
    queue_word(OP_FINISH, 8'h56, 1'b0);
    // finish on an incomplete path
    queue_word(OP_DESCEND, 8'h00, 1'b0);
    queue_word(OP_DESCEND, 8'h00, 1'b0);
    queue_word(OP_FINISH, 8'h3C, 1'b0);
    // full-depth left spine, one descend too many, then leaf and finish there
    for (k = 0; k < DepthLimit; k++) queue_word(OP_DESCEND, 8'($urandom_range(0, 255)), 1'b0);
    queue_word(OP_DESCEND, 8'hFF, 1'b0);
    queue_word(OP_LEAF, 8'hEE, 1'b0);
    queue_word(OP_FINISH, 8'h11, 1'b0);

    // Random trees; no finish until the leaf index has wrapped once
    rand_words = 0;
    leaf_run = 0;
    wrapped = 1'b0;
    hold_first = 1'b1;
    while (rand_words < 1400) begin
      pick = $urandom_range(0, 9);
      shape = (pick < 5) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
      cap = ($urandom_range(0, 3) == 0) ? DepthLimit : $urandom_range(2, 10);
      if (shape == 3) begin
        cap = $urandom_range(8, DepthLimit);
        grow_tree(cap, shape, 2 * DepthLimit + 4);
      end else begin
        grow_tree(cap, shape, $urandom_range(4, 60));
      end
      if (wrapped && $urandom_range(0, 99) < 60) begin
        w = tree_q.pop_back();
        w.operation = OP_FINISH;
        tree_q.push_back(w);
      end
      // broken walk: a stray word somewhere, then finish to get back to the root
      if (wrapped && $urandom_range(0, 99) < 15) begin
        w.operation = 2'($urandom_range(0, 3));
        w.symbol = 8'($urandom_range(0, 255));
        tree_q.insert($urandom_range(0, tree_q.size()), w);
        w.operation = OP_FINISH;
        tree_q.push_back(w);
      end
      // pure noise burst
      if (wrapped && $urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(1, 6)) begin
          w.operation = 2'($urandom_range(0, 3));
          w.symbol = 8'($urandom_range(0, 255));
          tree_q.push_back(w);
        end
        w.operation = OP_FINISH;
        tree_q.push_back(w);
      end
      for (k = 0; k < tree_q.size(); k++) begin
        queue_word(tree_q[k].operation, tree_q[k].symbol,
                   k == 0 && (hold_first || $urandom_range(0, 99) < 3));
        if (tree_q[k].operation == OP_LEAF) leaf_run++;
        if (tree_q[k].operation == OP_FINISH) leaf_run = 0;
        if (leaf_run >= 540) wrapped = 1'b1;
      end
      hold_first = 1'b0;
      rand_words += tree_q.size();
    end

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    while (walk_q.size() != 0 || in_valid || leaf_codes_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("preorder_tree_code_rebuilder_top verification clean");
    end else begin
      $display("preorder_tree_code_rebuilder_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ptcr_pkg.sv
hw/rtl/ptcr_step.sv
hw/rtl/preorder_tree_code_rebuilder_top.sv
hw/rtl/ptcr_checker.sv
tb/sv/preorder_tree_code_rebuilder_top_test.sv
